// File: rtl/pws_pkg.sv
package pws_pkg;

  localparam int DEFAULT_COORD_BITS = 20;

  localparam int AXIS_BITS   = 16;
  localparam int ORIGIN_BITS = 60;
  localparam int FOCAL_BITS  = 16;
  localparam int CFG_BITS    = 60;
  localparam int IDX_BITS    = 3;
  localparam int SCR_BITS    = 16;

  // quotient bits kept before the cap, cap itself
  localparam int QUOT_BITS = 21;
  localparam int QUOT_CAP  = 1048576;

  // 0.001 world units in units of 2^-18
  localparam int DEPTH_EPS = 262;

  // screen centre in q12.4
  localparam int CENTER_X = 5120;
  localparam int CENTER_Y = 3840;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ORIGIN  = 3'd0,
    REG_FORWARD = 3'd1,
    REG_RIGHT   = 3'd2,
    REG_UP      = 3'd3,
    REG_FOCAL_X = 3'd4,
    REG_FOCAL_Y = 3'd5
  } cfg_reg_t;

  localparam logic [ORIGIN_BITS-1:0] ORIGIN_RST  = '0;
  localparam logic [3*AXIS_BITS-1:0] FORWARD_RST = 48'h0000_0000_4000;
  localparam logic [3*AXIS_BITS-1:0] RIGHT_RST   = 48'h0000_4000_0000;
  localparam logic [3*AXIS_BITS-1:0] UP_RST      = 48'h4000_0000_0000;
  localparam logic [FOCAL_BITS-1:0]  FOCAL_X_RST = 16'd5120;
  localparam logic [FOCAL_BITS-1:0]  FOCAL_Y_RST = 16'd3840;

endpackage

// File: rtl/perspective_world_to_screen.sv
// channel   | handshake          | payload
// point in  | pt_valid/pt_stall   | point_x, point_y, point_z
// screen out| scr_valid/scr_stall | in_front, screen_x, screen_y, clipped
// config    | cfg_we              | cfg_index, cfg_data
//
// one point per cycle while the output is not stalled
// the divider is a restoring one, one quotient bit per stage
// rst clears the valid bits and loads the camera registers with their defaults
// a stalled output freezes the whole pipeline; bubbles travel with it
module perspective_world_to_screen #(
  parameter int COORD_BITS = pws_pkg::DEFAULT_COORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pt_valid,
  output logic                                 pt_stall,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [COORD_BITS-1:0]         point_z,
  output logic                                 scr_valid,
  input  logic                                 scr_stall,
  output logic                                 in_front,
  output logic signed [pws_pkg::SCR_BITS-1:0]  screen_x,
  output logic signed [pws_pkg::SCR_BITS-1:0]  screen_y,
  output logic                                 clipped,
  input  logic                                 cfg_we,
  input  logic [pws_pkg::IDX_BITS-1:0]         cfg_index,
  input  logic [pws_pkg::CFG_BITS-1:0]         cfg_data
);
  import pws_pkg::*;

  localparam int T_BITS   = COORD_BITS + 1;
  localparam int P_BITS   = T_BITS + AXIS_BITS;
  localparam int DOT_BITS = P_BITS + 2;
  localparam int NUM_BITS = DOT_BITS + FOCAL_BITS + 1;
  localparam int W        = NUM_BITS + QUOT_BITS + 1;
  localparam int EXT_BITS = (3*COORD_BITS > ORIGIN_BITS) ? 3*COORD_BITS : ORIGIN_BITS;
  localparam int R_BITS   = QUOT_BITS + 3;

  // configuration
  logic [ORIGIN_BITS-1:0]  origin;
  logic [3*AXIS_BITS-1:0]  axis [3];
  logic [FOCAL_BITS-1:0]   focal_x, focal_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin  <= ORIGIN_RST;
      axis[0] <= FORWARD_RST;
      axis[1] <= RIGHT_RST;
      axis[2] <= UP_RST;
      focal_x <= FOCAL_X_RST;
      focal_y <= FOCAL_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN:  origin  <= cfg_data[ORIGIN_BITS-1:0];
        REG_FORWARD: axis[0] <= cfg_data[3*AXIS_BITS-1:0];
        REG_RIGHT:   axis[1] <= cfg_data[3*AXIS_BITS-1:0];
        REG_UP:      axis[2] <= cfg_data[3*AXIS_BITS-1:0];
        REG_FOCAL_X: focal_x <= cfg_data[FOCAL_BITS-1:0];
        REG_FOCAL_Y: focal_y <= cfg_data[FOCAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !scr_valid || !scr_stall;
  assign pt_stall = !en;

  // stage 1: offset from camera
  logic [EXT_BITS-1:0]       origin_ext;
  logic signed [T_BITS-1:0]  t_next [3];
  logic signed [T_BITS-1:0]  t [3];
  logic                      v1;
  logic signed [COORD_BITS-1:0] pt [3];

  assign origin_ext = EXT_BITS'(origin);
  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_next[i] = T_BITS'(pt[i])
                - T_BITS'($signed(origin_ext[i*COORD_BITS +: COORD_BITS]));
    end
  end

  // stage 2: nine products, p[i][j] = t[i] * axis j component i
  logic signed [P_BITS-1:0] p [3][3];
  logic                     v2;

  // stage 3: three dot products
  logic signed [DOT_BITS-1:0] dot [3];
  logic                       v3;

  // stage 4: sign, magnitude, focal scaling
  logic                       v4, bh4, nx4, ny4;
  logic [DOT_BITS-1:0]        d4;
  logic [DOT_BITS+FOCAL_BITS-1:0] px4, py4;
  logic [DOT_BITS-1:0]        mx, my;

  assign mx = dot[1][DOT_BITS-1] ? DOT_BITS'(-dot[1]) : DOT_BITS'(dot[1]);
  assign my = dot[2][DOT_BITS-1] ? DOT_BITS'(-dot[2]) : DOT_BITS'(dot[2]);

  // stage 5: add half the divisor for rounding
  logic                       v5, bh5, nx5, ny5;
  logic [DOT_BITS-1:0]        d5;
  logic [NUM_BITS-1:0]        nmx5, nmy5;

  // divider pipeline, index 0 written by the overflow check stage
  logic [W-1:0]          rx [QUOT_BITS+1];
  logic [W-1:0]          ry [QUOT_BITS+1];
  logic [QUOT_BITS-1:0]  qx [QUOT_BITS+1];
  logic [QUOT_BITS-1:0]  qy [QUOT_BITS+1];
  logic [DOT_BITS-1:0]   dd [QUOT_BITS+1];
  logic                  vd [QUOT_BITS+1];
  logic                  bh [QUOT_BITS+1];
  logic                  nx [QUOT_BITS+1];
  logic                  ny [QUOT_BITS+1];
  logic                  ox [QUOT_BITS+1];
  logic                  oy [QUOT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vd[0] <= 1'b0;
    end else if (en) begin
      v1 <= pt_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vd[0] <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t <= t_next;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= t[i] * $signed(axis[j][i*AXIS_BITS +: AXIS_BITS]);
        end
      end
      for (int j = 0; j < 3; j++) begin
        dot[j] <= DOT_BITS'(p[0][j]) + DOT_BITS'(p[1][j]) + DOT_BITS'(p[2][j]);
      end
      bh4 <= dot[0] <= DOT_BITS'(DEPTH_EPS);
      nx4 <= dot[1][DOT_BITS-1];
      ny4 <= dot[2][DOT_BITS-1];
      d4  <= dot[0];
      px4 <= (DOT_BITS+FOCAL_BITS)'(mx) * (DOT_BITS+FOCAL_BITS)'(focal_x);
      py4 <= (DOT_BITS+FOCAL_BITS)'(my) * (DOT_BITS+FOCAL_BITS)'(focal_y);
      bh5  <= bh4;
      nx5  <= nx4;
      ny5  <= ny4;
      d5   <= d4;
      nmx5 <= NUM_BITS'(px4) + NUM_BITS'(d4 >> 1);
      nmy5 <= NUM_BITS'(py4) + NUM_BITS'(d4 >> 1);
      // a quotient of 2^QUOT_BITS or more is capped anyway
      ox[0] <= W'(nmx5) >= (W'(d5) << QUOT_BITS);
      oy[0] <= W'(nmy5) >= (W'(d5) << QUOT_BITS);
      rx[0] <= W'(nmx5);
      ry[0] <= W'(nmy5);
      qx[0] <= '0;
      qy[0] <= '0;
      dd[0] <= d5;
      bh[0] <= bh5;
      nx[0] <= nx5;
      ny[0] <= ny5;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_div
    localparam int K = QUOT_BITS - 1 - s;
    logic [W-1:0] dsh;
    logic         gx, gy;
    assign dsh = W'(dd[s]) << K;
    assign gx  = rx[s] >= dsh;
    assign gy  = ry[s] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else if (en) begin
        vd[s+1] <= vd[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[s+1]    <= gx ? rx[s] - dsh : rx[s];
        ry[s+1]    <= gy ? ry[s] - dsh : ry[s];
        qx[s+1]    <= qx[s] | (QUOT_BITS'(gx) << K);
        qy[s+1]    <= qy[s] | (QUOT_BITS'(gy) << K);
        dd[s+1]    <= dd[s];
        bh[s+1]    <= bh[s];
        nx[s+1]    <= nx[s];
        ny[s+1]    <= ny[s];
        ox[s+1]    <= ox[s];
        oy[s+1]    <= oy[s];
      end
    end
  end

  // output stage: cap, sign, offset from centre, saturate
  logic [R_BITS-1:0]        cqx, cqy;
  logic signed [R_BITS-1:0] sx, sy;
  logic                     satx, saty;
  logic signed [SCR_BITS-1:0] fx, fy;

  always_comb begin
    cqx = (ox[QUOT_BITS] || qx[QUOT_BITS] > QUOT_BITS'(QUOT_CAP))
        ? R_BITS'(QUOT_CAP) : R_BITS'(qx[QUOT_BITS]);
    cqy = (oy[QUOT_BITS] || qy[QUOT_BITS] > QUOT_BITS'(QUOT_CAP))
        ? R_BITS'(QUOT_CAP) : R_BITS'(qy[QUOT_BITS]);
    sx = nx[QUOT_BITS] ? R_BITS'(CENTER_X) + $signed(cqx)
                       : R_BITS'(CENTER_X) - $signed(cqx);
    sy = ny[QUOT_BITS] ? R_BITS'(CENTER_Y) + $signed(cqy)
                       : R_BITS'(CENTER_Y) - $signed(cqy);
    satx = 1'b0;
    saty = 1'b0;
    fx = sx[SCR_BITS-1:0];
    fy = sy[SCR_BITS-1:0];
    if (sx > R_BITS'(32767)) begin
      fx = 16'sh7fff;
      satx = 1'b1;
    end else if (sx < -R_BITS'(32768)) begin
      fx = -16'sh8000;
      satx = 1'b1;
    end
    if (sy > R_BITS'(32767)) begin
      fy = 16'sh7fff;
      saty = 1'b1;
    end else if (sy < -R_BITS'(32768)) begin
      fy = -16'sh8000;
      saty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_valid <= 1'b0;
    end else if (en) begin
      scr_valid <= vd[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_front <= !bh[QUOT_BITS];
      screen_x <= bh[QUOT_BITS] ? '0 : fx;
      screen_y <= bh[QUOT_BITS] ? '0 : fy;
      clipped  <= !bh[QUOT_BITS] && (satx || saty);
    end
  end

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    scr_valid && !in_front |-> screen_x == '0 && screen_y == '0 && !clipped)
    else $error("point behind camera with nonzero result");

  a_stall_only_blocked: assert property (@(posedge clk) disable iff (rst)
    pt_stall |-> scr_valid && scr_stall)
    else $error("input stalled while output free");

  a_last_stage_emerges: assert property (@(posedge clk) disable iff (rst)
    en && vd[QUOT_BITS] |=> scr_valid)
    else $error("item lost at output stage");

  a_first_stage_moves: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_stall |=> v1)
    else $error("accepted transfer not captured");

endmodule

// File: verif/perspective_world_to_screen_tb.sv
`timescale 1ns / 1ps

module perspective_world_to_screen_tb;
  import pws_pkg::*;

  localparam int CB = DEFAULT_COORD_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } point_t;

  typedef struct {
    bit                 front;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    bit                 clip;
  } screen_t;

  logic clk = 1'b0;
  logic rst;
  logic pt_valid;
  logic pt_stall;
  logic signed [CB-1:0] point_x, point_y, point_z;
  logic scr_valid;
  logic scr_stall;
  logic in_front;
  logic signed [SCR_BITS-1:0] screen_x, screen_y;
  logic clipped;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  perspective_world_to_screen u_dut (
    .clk(clk), .rst(rst),
    .pt_valid(pt_valid), .pt_stall(pt_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .scr_valid(scr_valid), .scr_stall(scr_stall),
    .in_front(in_front), .screen_x(screen_x), .screen_y(screen_y), .clipped(clipped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // camera copy used for prediction
  logic [ORIGIN_BITS-1:0] cam_origin;
  logic [3*AXIS_BITS-1:0] cam_fwd, cam_right, cam_up;
  logic [FOCAL_BITS-1:0]  cam_fx, cam_fy;

  point_t  pending_points[$];
  screen_t expected_screen[$];
  int src_idle_pct, dst_idle_pct;
  bit took;
  int errors, cycles, n_front, n_behind, n_clip, n_checked;

  function automatic longint axis_comp(logic [3*AXIS_BITS-1:0] a, int i);
    logic signed [AXIS_BITS-1:0] f;
    f = a[i*AXIS_BITS +: AXIS_BITS];
    return longint'(f);
  endfunction

  function automatic longint origin_comp(int i);
    logic signed [CB-1:0] f;
    f = cam_origin[i*CB +: CB];
    return longint'(f);
  endfunction

  function automatic longint dot_axis(longint t[3], logic [3*AXIS_BITS-1:0] a);
    return t[0]*axis_comp(a, 0) + t[1]*axis_comp(a, 1) + t[2]*axis_comp(a, 2);
  endfunction

  // rounded num*f/d, ties away from zero, split so nothing overflows 64 bits
  function automatic longint offset_quot(longint num, longint unsigned f,
                                         longint unsigned d);
    longint unsigned mag, hi, q1, r1, q2, q;
    mag = (num < 0) ? longint'(-num) : num;
    hi = mag * ((f >> 8) & 255);
    q1 = hi / d;
    r1 = hi % d;
    q2 = (r1 * 256 + mag * (f & 255) + d / 2) / d;
    q = q1 * 256 + q2;
    if (q > QUOT_CAP) q = QUOT_CAP;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic screen_t project_point(point_t p);
    screen_t r;
    longint t[3];
    longint depth, sx, sy;
    t[0] = longint'(p.x) - origin_comp(0);
    t[1] = longint'(p.y) - origin_comp(1);
    t[2] = longint'(p.z) - origin_comp(2);
    depth = dot_axis(t, cam_fwd);
    r = '{0, 0, 0, 0};
    if (depth <= DEPTH_EPS) return r;
    sx = CENTER_X - offset_quot(dot_axis(t, cam_right), cam_fx, depth);
    sy = CENTER_Y - offset_quot(dot_axis(t, cam_up), cam_fy, depth);
    r.front = 1;
    if (sx > 32767) begin sx = 32767; r.clip = 1; end
    if (sx < -32768) begin sx = -32768; r.clip = 1; end
    if (sy > 32767) begin sy = 32767; r.clip = 1; end
    if (sy < -32768) begin sy = -32768; r.clip = 1; end
    r.sx = sx[15:0];
    r.sy = sy[15:0];
    return r;
  endfunction

  // transfers in both directions, checking, timeout
  always @(posedge clk) begin
    screen_t e;
    cycles++;
    took = pt_valid && !pt_stall && !rst;
    if (took) expected_screen.push_back(project_point('{point_x, point_y, point_z}));
    if (!rst && scr_valid && !scr_stall) begin
      if (expected_screen.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: in_front=%0b x=%0d y=%0d clipped=%0b",
                 $time, in_front, screen_x, screen_y, clipped);
      end else begin
        e = expected_screen.pop_front();
        n_checked++;
        if (e.clip) n_clip++;
        if (e.front) n_front++; else n_behind++;
        if (in_front !== e.front || screen_x !== e.sx || screen_y !== e.sy ||
            clipped !== e.clip) begin
          errors++;
          $display("%0t: mismatch: expected in_front=%0b x=%0d y=%0d clipped=%0b",
                   $time, e.front, e.sx, e.sy, e.clip);
          $display("%0t:           actual   in_front=%0b x=%0d y=%0d clipped=%0b",
                   $time, in_front, screen_x, screen_y, clipped);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("perspective_world_to_screen_tb failed");
      $finish;
    end
  end

  // point driver and receiver stalls
  always @(negedge clk) begin
    point_t p;
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (!pt_valid || took) begin
      if (pending_points.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        p = pending_points.pop_front();
        pt_valid <= 1'b1;
        point_x <= p.x;
        point_y <= p.y;
        point_z <= p.z;
      end else begin
        pt_valid <= 1'b0;
      end
    end
    scr_stall <= ($urandom_range(99) < dst_idle_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ORIGIN:  cam_origin = val[ORIGIN_BITS-1:0];
      REG_FORWARD: cam_fwd = val[3*AXIS_BITS-1:0];
      REG_RIGHT:   cam_right = val[3*AXIS_BITS-1:0];
      REG_UP:      cam_up = val[3*AXIS_BITS-1:0];
      REG_FOCAL_X: cam_fx = val[FOCAL_BITS-1:0];
      REG_FOCAL_Y: cam_fy = val[FOCAL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_point(longint x, longint y, longint z);
    point_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    p.z = z[CB-1:0];
    pending_points.push_back(p);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || pt_valid || expected_screen.size() > 0)
      @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // axis with each component picked from plus or minus unit values, zero or random
  function automatic logic [3*AXIS_BITS-1:0] rand_axis();
    logic [3*AXIS_BITS-1:0] a;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(4))
        0: a[i*16 +: 16] = 16'h4000;
        1: a[i*16 +: 16] = 16'hC000;
        2: a[i*16 +: 16] = 16'h0000;
        default: a[i*16 +: 16] = 16'($urandom);
      endcase
    end
    return a;
  endfunction

  task automatic add_random(int n);
    longint c;
    int span;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(2) == 0) begin
        push_point($urandom, $urandom, $urandom);
      end else begin
        // near the camera, where points tend to land on screen
        span = 1 << $urandom_range(4, 14);
        push_point(origin_comp(0) + $urandom_range(2*span) - span,
                   origin_comp(1) + $urandom_range(2*span) - span,
                   origin_comp(2) + $urandom_range(2*span) - span);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    pt_valid = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    scr_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ORIGIN;
    cfg_data = '0;
    cam_origin = ORIGIN_RST;
    cam_fwd = FORWARD_RST;
    cam_right = RIGHT_RST;
    cam_up = UP_RST;
    cam_fx = FOCAL_X_RST;
    cam_fy = FOCAL_Y_RST;
    src_idle_pct = 37;
    dst_idle_pct = 87;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // default camera: centre, corner, behind, field extremes, saturation
    push_point(16, 0, 0);
    push_point(16, 16, 16);
    push_point(16, -16, -16);
    push_point(0, 0, 0);
    push_point(-16, 5, 5);
    push_point(524287, 524287, 524287);
    push_point(524287, -524288, -524288);
    push_point(-524288, 524287, 524287);
    push_point(1, 524287, -524288);
    push_point(3, 1, 2);
    drain();

    // raw forward unit so depth equals x offset: threshold edge, zero and max focal
    write_reg(REG_FORWARD, 48'h0000_0000_0001);
    write_reg(REG_FOCAL_X, 16'd0);
    write_reg(REG_FOCAL_Y, 16'hFFFF);
    push_point(262, 1, 1);
    push_point(263, 1, 1);
    push_point(263, -1, -1);
    push_point(264, 0, 0);
    push_point(524287, 3, -3);
    push_point(261, 100, 100);
    drain();

    // extreme camera: origin fields at both limits, most negative and most positive axis components
    write_reg(REG_ORIGIN, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(REG_FORWARD, 48'h8000_8000_8000);
    write_reg(REG_RIGHT, 48'h8000_7FFF_8000);
    write_reg(REG_UP, 48'h7FFF_8000_0000);
    push_point(-524288, -524288, -524288);
    push_point(524287, 524287, 524287);
    push_point(-524288, 524287, -524288);
    push_point(0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      src_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 87 : 0;
      dst_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 37 : 0;
      write_reg(REG_ORIGIN, (ph == 5) ? CFG_BITS'(0) : CFG_BITS'(rand64()));
      write_reg(REG_FORWARD, (ph == 0) ? FORWARD_RST : rand_axis());
      write_reg(REG_RIGHT, (ph == 0) ? RIGHT_RST : rand_axis());
      write_reg(REG_UP, (ph == 0) ? UP_RST : rand_axis());
      write_reg(REG_FOCAL_X, (ph == 3) ? 16'hFFFF : (ph == 4) ? 16'h0 : $urandom_range(65535));
      write_reg(REG_FOCAL_Y, (ph == 4) ? 16'hFFFF : $urandom_range(1, 12000));
      add_random(88);
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("checked %0d transfers over 9 camera settings: %0d in front, %0d behind, %0d clipped",
             n_checked, n_front, n_behind, n_clip);
    $display("%0d errors", errors);
    if (errors == 0 && expected_screen.size() == 0)
      $display("perspective_world_to_screen_tb passed");
    else
      $display("perspective_world_to_screen_tb failed");
    $finish;
  end

endmodule

// File: perspective_world_to_screen.f
rtl/pws_pkg.sv
rtl/perspective_world_to_screen.sv
verif/perspective_world_to_screen_tb.sv
